// ===== design/rxz_pkg.sv =====
package rxz_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned WordBits = 32;
  localparam int unsigned TexBits = 17;
  localparam int unsigned TexFracBits = 16;

  typedef enum logic [2:0] {
    REG_X_LO   = 3'd0,
    REG_X_HI   = 3'd1,
    REG_Z_LO   = 3'd2,
    REG_Z_HI   = 3'd3,
    REG_HEIGHT = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic signed [WordBits-1:0] x_lo;
    logic signed [WordBits-1:0] x_hi;
    logic signed [WordBits-1:0] z_lo;
    logic signed [WordBits-1:0] z_hi;
    logic signed [WordBits-1:0] height;
  } rect_cfg_t;

  // Face normal of the upper face.
  localparam logic signed [1:0] NormalUp   = 2'sd1;
  localparam logic signed [1:0] NormalDown = -2'sd1;

endpackage

// ===== design/rxz_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, registered every
// stage, with a payload carried alongside the valid bit.  The pipeline
// advances only when enable is high.
module rxz_divider #(
  parameter int unsigned NUM_BITS = 48,
  parameter int unsigned DEN_BITS = 32,
  parameter int unsigned TAG_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                enable,
  input  logic                in_valid,
  input  logic [NUM_BITS-1:0] in_num,
  input  logic [DEN_BITS-1:0] in_den,
  input  logic [TAG_BITS-1:0] in_tag,
  output logic                out_valid,
  output logic [NUM_BITS-1:0] out_quo,
  output logic [DEN_BITS-1:0] out_rem,
  output logic [TAG_BITS-1:0] out_tag
);

  localparam int unsigned RemBits = DEN_BITS + 1;

  logic                valid [NUM_BITS+1];
  logic [NUM_BITS-1:0] quo   [NUM_BITS+1];
  logic [RemBits-1:0]  rem   [NUM_BITS+1];
  logic [DEN_BITS-1:0] den   [NUM_BITS+1];
  logic [TAG_BITS-1:0] tag   [NUM_BITS+1];

  assign valid[0] = in_valid;
  assign quo[0]   = in_num;
  assign rem[0]   = '0;
  assign den[0]   = in_den;
  assign tag[0]   = in_tag;

  for (genvar s = 0; s < NUM_BITS; s++) begin : g_stage
    logic [RemBits-1:0]  shifted;
    logic [RemBits-1:0]  diff;
    logic                take;
    assign shifted = {rem[s][DEN_BITS-1:0], quo[s][NUM_BITS-1]};
    assign diff    = shifted - {1'b0, den[s]};
    assign take    = shifted >= {1'b0, den[s]};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s+1] <= 1'b0;
      end else if (enable) begin
        valid[s+1] <= valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (enable) begin
        quo[s+1] <= {quo[s][NUM_BITS-2:0], take};
        rem[s+1] <= take ? diff : shifted;
        den[s+1] <= den[s];
        tag[s+1] <= tag[s];
      end
    end
  end

  assign out_valid = valid[NUM_BITS];
  assign out_quo   = quo[NUM_BITS];
  assign out_rem   = rem[NUM_BITS][DEN_BITS-1:0];
  assign out_tag   = tag[NUM_BITS];

endmodule

// ===== design/rxz_cfg_regs.sv =====
// Rectangle configuration registers.
module rxz_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output rxz_pkg::rect_cfg_t rect
);
  import rxz_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_X_LO:   rect.x_lo   <= cfg_data;
        REG_X_HI:   rect.x_hi   <= cfg_data;
        REG_Z_LO:   rect.z_lo   <= cfg_data;
        REG_Z_HI:   rect.z_hi   <= cfg_data;
        REG_HEIGHT: rect.height <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/ray_xz_rectangle_intersect.sv =====
// Ray against an axis-aligned rectangle in the plane y = height (the height register).
//
// Channels: the ray channel (in_valid/in_ready) carries one ray per
// transaction; the result channel (out_valid/out_ready) returns exactly one
// result per ray, in order.  The configuration channel (cfg_valid/cfg_ready)
// is always ready and writes one rectangle register per transaction; the user
// must write it only while no ray is in flight; the block does not enforce it.
//
// Throughput is one ray per cycle while the receiver does not stall.  The
// pipeline depth is set by two bit-per-stage divider chains: the t
// quotient, then the u and v quotients which run side by side.  The other
// stages are the input stage, four stages between the dividers and the
// output register.
//
// The whole pipeline moves as one when the output register is empty or
// being taken; when the receiver stalls, every stage holds, so no ray is
// lost or repeated.  in_ready follows the same condition.
//
// Reset clears every valid bit and the rectangle registers to zero.
module ray_xz_rectangle_intersect #(
  parameter int unsigned FRAC_BITS = rxz_pkg::FracBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic signed [31:0] t_lower,
  input  logic signed [31:0] t_upper,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_hit,
  output logic signed [31:0] hit_t,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic [16:0] tex_u,
  output logic [16:0] tex_v,
  output logic        front_face,
  output logic signed [1:0] normal_y
);
  import rxz_pkg::*;

  // The numerator |height - oy| needs 33 bits; shifted up by FRAC_BITS.
  localparam int unsigned TNumBits = WordBits + 1 + FRAC_BITS;
  localparam int unsigned TDenBits = WordBits;
  // Signed t: one bit above the unsigned quotient.
  localparam int unsigned TBits    = TNumBits + 1;
  // Texture: offset and extent are 33-bit non-negative values.
  localparam int unsigned ExtBits  = WordBits + 1;
  localparam int unsigned UNumBits = ExtBits + TexFracBits;
  localparam int unsigned TagBits  = 8 * WordBits + 2;

  rect_cfg_t rect;
  logic      adv;

  rxz_cfg_regs u_cfg (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .rect
  );

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---- Stage A: numerator and sign prep ------------------------------
  logic                       a_valid;
  logic signed [WordBits:0]   a_num;
  logic signed [WordBits-1:0] a_ox, a_oz, a_dx, a_dz, a_dy, a_tlo, a_thi;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (adv) a_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_num <= {rect.height[WordBits-1], rect.height} - {origin_y[WordBits-1], origin_y};
      a_ox  <= origin_x;
      a_oz  <= origin_z;
      a_dx  <= dir_x;
      a_dy  <= dir_y;
      a_dz  <= dir_z;
      a_tlo <= t_lower;
      a_thi <= t_upper;
    end
  end

  logic [WordBits:0]   a_num_mag;
  logic [WordBits-1:0] a_dy_mag;
  logic [TNumBits-1:0] a_div_num;
  logic                a_neg;
  logic [TagBits-1:0]  a_tag;

  assign a_num_mag = a_num[WordBits] ? -a_num : a_num;
  assign a_dy_mag  = a_dy[WordBits-1] ? -a_dy : a_dy;
  assign a_div_num = {a_num_mag, {FRAC_BITS{1'b0}}};
  assign a_neg     = a_num[WordBits] ^ a_dy[WordBits-1];
  assign a_tag     = {a_neg, (a_dy == '0), a_ox, a_oz, a_dx, a_dz, a_tlo, a_thi,
                      a_dy[WordBits-1], {(2*WordBits-1){1'b0}}};

  // ---- t divider -------------------------------------------------------
  logic                t_valid;
  logic [TNumBits-1:0] t_quo;
  logic [TDenBits-1:0] t_rem;
  logic [TagBits-1:0]  t_tag;

  rxz_divider #(.NUM_BITS(TNumBits), .DEN_BITS(TDenBits), .TAG_BITS(TagBits)) u_tdiv (
    .clk, .rst, .enable(adv), .in_valid(a_valid),
    .in_num(a_div_num), .in_den(a_dy_mag), .in_tag(a_tag),
    .out_valid(t_valid), .out_quo(t_quo), .out_rem(t_rem), .out_tag(t_tag)
  );

  // ---- Stage B: sign t, interval test ---------------------------------
  logic                       b_valid, b_miss, b_front;
  logic signed [TBits-1:0]    b_t;
  logic signed [WordBits-1:0] b_ox, b_oz, b_dx, b_dz;
  logic                       t_neg, t_zero_dy, t_front;
  logic signed [WordBits-1:0] t_ox, t_oz, t_dx, t_dz, t_tlo, t_thi;
  logic signed [TBits-1:0]    t_signed;

  assign t_neg     = t_tag[TagBits-1];
  assign t_zero_dy = t_tag[TagBits-2];
  assign t_ox      = t_tag[TagBits-3 -: WordBits];
  assign t_oz      = t_tag[TagBits-3-WordBits -: WordBits];
  assign t_dx      = t_tag[TagBits-3-2*WordBits -: WordBits];
  assign t_dz      = t_tag[TagBits-3-3*WordBits -: WordBits];
  assign t_tlo     = t_tag[TagBits-3-4*WordBits -: WordBits];
  assign t_thi     = t_tag[TagBits-3-5*WordBits -: WordBits];
  assign t_front   = t_tag[2*WordBits-1];
  assign t_signed  = t_neg ? -$signed({1'b0, t_quo}) : $signed({1'b0, t_quo});

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (adv) b_valid <= t_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_t     <= t_signed;
      b_miss  <= t_zero_dy || (t_signed < TBits'(t_tlo)) || (t_signed > TBits'(t_thi));
      b_front <= t_front;
      b_ox    <= t_ox;
      b_oz    <= t_oz;
      b_dx    <= t_dx;
      b_dz    <= t_dz;
    end
  end

  // The divider remainder is not needed for t.
  logic t_rem_unused;
  assign t_rem_unused = ^t_rem;

  // ---- Stage C: products (t stays in 32 bits whenever it is a hit) -----
  logic                         c_valid, c_miss, c_front;
  logic signed [WordBits-1:0]   c_t;
  logic signed [2*WordBits-1:0] c_px, c_pz;
  logic signed [WordBits-1:0]   c_ox, c_oz;
  logic                         b_t_fits;

  assign b_t_fits = (b_t == TBits'($signed(b_t[WordBits-1:0])));

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else if (adv) c_valid <= b_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_t     <= b_t[WordBits-1:0];
      c_px    <= $signed(b_t[WordBits-1:0]) * b_dx;
      c_pz    <= $signed(b_t[WordBits-1:0]) * b_dz;
      c_miss  <= b_miss || !b_t_fits;
      c_front <= b_front;
      c_ox    <= b_ox;
      c_oz    <= b_oz;
    end
  end

  // ---- Stage D: hit point (arithmetic shift is a floor) ----------------
  localparam int unsigned PtBits = 2 * WordBits - FRAC_BITS + 1;
  logic                       d_valid, d_miss, d_front;
  logic signed [WordBits-1:0] d_t;
  logic signed [PtBits-1:0]   d_x, d_z;

  always_ff @(posedge clk) begin
    if (rst) d_valid <= 1'b0;
    else if (adv) d_valid <= c_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_t     <= c_t;
      d_x     <= PtBits'(c_px >>> FRAC_BITS) + PtBits'(c_ox);
      d_z     <= PtBits'(c_pz >>> FRAC_BITS) + PtBits'(c_oz);
      d_miss  <= c_miss;
      d_front <= c_front;
    end
  end

  // ---- Stage E: bound tests and texture offsets ------------------------
  logic                       e_valid, e_hit, e_front;
  logic signed [WordBits-1:0] e_t, e_x, e_z;
  logic [ExtBits-1:0]         e_uoff, e_voff, e_uext, e_vext;
  logic                       d_in;

  assign d_in = (d_x >= PtBits'(rect.x_lo)) && (d_x <= PtBits'(rect.x_hi)) &&
                (d_z >= PtBits'(rect.z_lo)) && (d_z <= PtBits'(rect.z_hi));

  always_ff @(posedge clk) begin
    if (rst) e_valid <= 1'b0;
    else if (adv) e_valid <= d_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_hit   <= !d_miss && d_in;
      e_front <= d_front;
      e_t     <= d_t;
      e_x     <= d_x[WordBits-1:0];
      e_z     <= d_z[WordBits-1:0];
      e_uoff  <= ExtBits'(d_x - PtBits'(rect.x_lo));
      e_voff  <= ExtBits'(d_z - PtBits'(rect.z_lo));
      e_uext  <= ExtBits'({rect.x_hi[WordBits-1], rect.x_hi} -
                          {rect.x_lo[WordBits-1], rect.x_lo});
      e_vext  <= ExtBits'({rect.z_hi[WordBits-1], rect.z_hi} -
                          {rect.z_lo[WordBits-1], rect.z_lo});
    end
  end

  // ---- u and v dividers -----------------------------------------------
  // On a hit the offsets lie in [0, ext], so the quotient is at most 65536.
  localparam int unsigned UTagBits = 3 * WordBits + 3;
  logic [UTagBits-1:0] e_tag, u_tag, v_tag_unused;
  logic                u_valid, v_valid_unused;
  logic [UNumBits-1:0] u_quo, v_quo;
  logic [ExtBits-1:0]  u_rem_unused, v_rem_unused;

  assign e_tag = {e_hit, e_front, (e_uext == '0 || e_vext == '0), e_t, e_x, e_z};

  rxz_divider #(.NUM_BITS(UNumBits), .DEN_BITS(ExtBits), .TAG_BITS(UTagBits)) u_udiv (
    .clk, .rst, .enable(adv), .in_valid(e_valid),
    .in_num({e_uoff, {TexFracBits{1'b0}}}), .in_den(e_uext), .in_tag(e_tag),
    .out_valid(u_valid), .out_quo(u_quo), .out_rem(u_rem_unused), .out_tag(u_tag)
  );

  rxz_divider #(.NUM_BITS(UNumBits), .DEN_BITS(ExtBits), .TAG_BITS(UTagBits)) u_vdiv (
    .clk, .rst, .enable(adv), .in_valid(e_valid),
    .in_num({e_voff, {TexFracBits{1'b0}}}), .in_den(e_vext), .in_tag(e_tag),
    .out_valid(v_valid_unused), .out_quo(v_quo), .out_rem(v_rem_unused),
    .out_tag(v_tag_unused)
  );

  // A zero extent makes the divider return all ones; those are replaced
  // with zero below.  The degenerate flag covers either axis, so keep the
  // per-axis test here instead.
  logic f_hit, f_front;
  logic u_deg, v_deg;
  assign f_hit   = u_tag[UTagBits-1];
  assign f_front = u_tag[UTagBits-2];
  assign u_deg   = (u_quo > UNumBits'(1 << TexFracBits));
  assign v_deg   = (v_quo > UNumBits'(1 << TexFracBits));

  // ---- Output register -------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= u_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      is_hit     <= f_hit;
      hit_t      <= f_hit ? u_tag[3*WordBits-1 -: WordBits] : '0;
      point_x    <= f_hit ? u_tag[2*WordBits-1 -: WordBits] : '0;
      point_y    <= f_hit ? rect.height : '0;
      point_z    <= f_hit ? u_tag[WordBits-1:0] : '0;
      tex_u      <= (f_hit && !u_deg) ? u_quo[TexBits-1:0] : '0;
      tex_v      <= (f_hit && !v_deg) ? v_quo[TexBits-1:0] : '0;
      front_face <= f_hit && f_front;
      normal_y   <= !f_hit ? 2'sd0 : (f_front ? NormalUp : NormalDown);
    end
  end

  logic unused_bits;
  assign unused_bits = ^{u_rem_unused, v_rem_unused, v_tag_unused, v_valid_unused,
                         u_tag[3*WordBits], t_rem_unused};

endmodule

// ===== design/rxz_checker.sv =====
module rxz_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic is_hit,
  input logic front_face,
  input logic signed [1:0] normal_y,
  input logic [16:0] tex_u
);

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready)) else $error("ready mismatch");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_hit |-> normal_y == 2'sd0 && !front_face && tex_u == '0)
    else $error("miss fields not zero");

  a_normal: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_hit |-> (front_face && normal_y == 2'sd1) ||
                            (!front_face && normal_y == -2'sd1))
    else $error("normal mismatch");

endmodule

bind ray_xz_rectangle_intersect rxz_checker u_rxz_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
  .is_hit, .front_face, .normal_y, .tex_u
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps

// Testbench for ray_xz_rectangle_intersect.
//
// Rays go in on the valid/ready ray channel and results come back on the
// result channel, one per ray and in order. A monitor watches both channels
// at every rising edge. Each accepted ray transaction is run through a
// software prediction of the intersection, and the expected result is
// queued. Each accepted result transaction is compared field by field with
// the oldest queued expectation.
//
// The run has several phases, each with its own rectangle and plane height.
// These include a small box, the full 32-bit range, a degenerate x extent,
// inverted bounds, and extreme plane heights. Rectangle registers are
// written only when the pipeline is empty. Most random rays are built to
// strike at or near the rectangle, and the rest are unconstrained noise.
module tb;
  import rxz_pkg::*;

  typedef struct {
    logic signed [31:0] ox, oy, oz, dx, dy, dz, tlo, thi;
  } ray_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] t, px, py, pz;
    logic [16:0]        u, v;
    logic               front;
    logic signed [1:0]  ny;
  } hit_rec_t;

  // Keeps a private copy of the rectangle registers and the queue of
  // expected results. Predictions use 128-bit signed arithmetic so that no
  // intermediate product or sum can wrap.
  class intersect_scoreboard;
    logic signed [31:0] x_lo, x_hi, z_lo, z_hi, height;
    hit_rec_t           pending_hits[$];
    int                 errors;
    int                 hits_seen;
    int                 results_seen;

    function new();
      x_lo = 0; x_hi = 0; z_lo = 0; z_hi = 0; height = 0;
      errors = 0; hits_seen = 0; results_seen = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_X_LO:   x_lo = data;
        REG_X_HI:   x_hi = data;
        REG_Z_LO:   z_lo = data;
        REG_Z_HI:   z_hi = data;
        REG_HEIGHT: height = data;
        default: ;
      endcase
    endfunction

    // Texture fraction of off within ext. It is zero when the extent is
    // zero or negative.
    function logic [16:0] tex_fraction(logic signed [127:0] off, logic signed [127:0] ext);
      logic signed [127:0] q;
      if (ext <= 0 || off < 0) return '0;
      q = (off <<< 16) / ext;
      return q[16:0];
    endfunction

    function void note_ray(ray_t r);
      hit_rec_t e;
      logic signed [127:0] num, den, q, t, x, z, ox, oz, dx, dz;
      e = '{hit: 0, t: 0, px: 0, py: 0, pz: 0, u: 0, v: 0, front: 0, ny: 0};
      ox = r.ox; oz = r.oz; dx = r.dx; dz = r.dz;
      if (r.dy != 0) begin
        num = height;
        num = num - r.oy;
        den = r.dy;
        q = ((num < 0 ? -num : num) <<< FracBitsDefault) / (den < 0 ? -den : den);
        // The quotient truncates toward zero, so its sign is applied after
        // the division.
        t = ((num < 0) != (den < 0)) ? -q : q;
        if (t >= r.tlo && t <= r.thi) begin
          x = ox + ((t * dx) >>> FracBitsDefault);
          z = oz + ((t * dz) >>> FracBitsDefault);
          if (x >= x_lo && x <= x_hi && z >= z_lo && z <= z_hi) begin
            e.hit = 1;
            e.t = t[31:0];
            e.px = x[31:0];
            e.py = height;
            e.pz = z[31:0];
            e.u = tex_fraction(x - x_lo, 128'(x_hi) - 128'(x_lo));
            e.v = tex_fraction(z - z_lo, 128'(z_hi) - 128'(z_lo));
            e.front = r.dy < 0;
            e.ny = e.front ? NormalUp : NormalDown;
          end
        end
      end
      pending_hits.push_back(e);
    endfunction

    function void check_result(hit_rec_t a);
      hit_rec_t e;
      results_seen++;
      if (pending_hits.size() == 0) begin
        $display("%0t: result with no ray outstanding", $time);
        errors++;
        return;
      end
      e = pending_hits.pop_front();
      if (e.hit) hits_seen++;
      if (a.hit !== e.hit) begin
        $display("%0t: is_hit exp %0d got %0d", $time, e.hit, a.hit); errors++;
      end
      if (a.t !== e.t) begin
        $display("%0t: hit_t exp %0d got %0d", $time, e.t, a.t); errors++;
      end
      if (a.px !== e.px) begin
        $display("%0t: point_x exp %0d got %0d", $time, e.px, a.px); errors++;
      end
      if (a.py !== e.py) begin
        $display("%0t: point_y exp %0d got %0d", $time, e.py, a.py); errors++;
      end
      if (a.pz !== e.pz) begin
        $display("%0t: point_z exp %0d got %0d", $time, e.pz, a.pz); errors++;
      end
      if (a.u !== e.u) begin
        $display("%0t: tex_u exp %0d got %0d", $time, e.u, a.u); errors++;
      end
      if (a.v !== e.v) begin
        $display("%0t: tex_v exp %0d got %0d", $time, e.v, a.v); errors++;
      end
      if (a.front !== e.front) begin
        $display("%0t: front_face exp %0d got %0d", $time, e.front, a.front); errors++;
      end
      if (a.ny !== e.ny) begin
        $display("%0t: normal_y exp %0d got %0d", $time, e.ny, a.ny); errors++;
      end
    endfunction
  endclass

  localparam int Latency = 200;
  localparam int CycleLimit = 600000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] origin_x = 0, origin_y = 0, origin_z = 0;
  logic signed [31:0] dir_x = 0, dir_y = 0, dir_z = 0, t_lower = 0, t_upper = 0;
  logic out_valid;
  logic out_ready = 0;
  logic is_hit;
  logic signed [31:0] hit_t, point_x, point_y, point_z;
  logic [16:0] tex_u, tex_v;
  logic front_face;
  logic signed [1:0] normal_y;

  intersect_scoreboard sb = new();
  int cycles = 0;
  bit burst_mode = 0;
  int rays_sent = 0;

  always #5 clk = ~clk;

  ray_xz_rectangle_intersect i_dut (.*);

  // The monitor samples at the edge itself, so it sees the values that
  // the edge captures.
  always @(posedge clk) begin
    hit_rec_t a;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("ray_xz_rectangle_intersect test failed");
      $finish;
    end
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready)
        sb.note_ray('{origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_lower, t_upper});
      if (out_valid && out_ready) begin
        a = '{is_hit, hit_t, point_x, point_y, point_z, tex_u, tex_v, front_face, normal_y};
        sb.check_result(a);
      end
    end
  end

  // The receiver stalls a random number of cycles before taking each
  // result, except in burst stretches, where it takes one every cycle.
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = burst_mode ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Leaves cfg_valid high. The caller lowers it once its writes are done.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_rect(int xl, int xh, int zl, int zh, int h);
    write_reg(REG_X_LO, xl);
    write_reg(REG_X_HI, xh);
    write_reg(REG_Z_LO, zl);
    write_reg(REG_Z_HI, zh);
    write_reg(REG_HEIGHT, h);
    // Indexes above the last register are ignored by the block.
    write_reg(3'($urandom_range(5, 7)), $urandom);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Sends one ray after an optional gap. in_valid stays high when the
  // next ray follows with no gap.
  task automatic send_ray(ray_t r);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    {origin_x, origin_y, origin_z} <= {r.ox, r.oy, r.oz};
    {dir_x, dir_y, dir_z} <= {r.dx, r.dy, r.dz};
    {t_lower, t_upper} <= {r.tlo, r.thi};
    do @(posedge clk); while (!in_ready);
    rays_sent++;
    if (rays_sent % 97 == 0) burst_mode = ~burst_mode;
  endtask

  // Lowers in_valid, waits until every result has arrived, then waits a margin set by Latency.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
  endtask

  function automatic ray_t mk(int ox, int oy, int oz, int dx, int dy, int dz, int tl, int th);
    ray_t r;
    r = '{ox, oy, oz, dx, dy, dz, tl, th};
    return r;
  endfunction

  // Builds a ray aimed at a point in or near the rectangle at an integer
  // t, so that the intended hit point is reached exactly.
  function automatic ray_t aimed_ray();
    ray_t r;
    longint span, tx, tz, k;
    span = longint'(sb.x_hi) - longint'(sb.x_lo);
    tx = sb.x_lo + (span >= 0 ? longint'({$urandom, $urandom} % (span + 1)) : 0);
    span = longint'(sb.z_hi) - longint'(sb.z_lo);
    tz = sb.z_lo + (span >= 0 ? longint'({$urandom, $urandom} % (span + 1)) : 0);
    // Nudge the target by up to two units now and then, which can pull it just off an edge.
    if ($urandom_range(0, 7) == 0) tx = tx + $signed($urandom_range(0, 4)) - 2;
    if ($urandom_range(0, 7) == 0) tz = tz + $signed($urandom_range(0, 4)) - 2;
    k = $urandom_range(0, 40);
    r.dx = $signed($urandom) >>> $urandom_range(8, 20);
    r.dy = $signed($urandom) >>> $urandom_range(8, 20);
    r.dz = $signed($urandom) >>> $urandom_range(8, 20);
    if (r.dy == 0) r.dy = 32'sh10000;
    r.ox = 32'(tx - k * r.dx);
    r.oz = 32'(tz - k * r.dz);
    r.oy = 32'(longint'(sb.height) - k * r.dy);
    r.tlo = 32'((k << 16) - $urandom_range(0, 2) * 65536 + $urandom_range(0, 1));
    r.thi = 32'((k << 16) + $urandom_range(0, 2) * 65536 - $urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) begin
      r.tlo = 32'h8000_0000;
      r.thi = 32'h7fff_ffff;
    end
    return r;
  endfunction

  function automatic ray_t noise_ray();
    ray_t r;
    r = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 1)) r.tlo = 32'h8000_0000;
    if ($urandom_range(0, 1)) r.thi = 32'h7fff_ffff;
    return r;
  endfunction

  task automatic random_rays(int count);
    repeat (count) send_ray($urandom_range(0, 3) != 0 ? aimed_ray() : noise_ray());
  endtask

  localparam int One = 32'sh10000;
  localparam int IMin = 32'sh8000_0000;
  localparam int IMax = 32'sh7fff_ffff;

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed rays against a box of half-width 4 in the plane y = 2.
    set_rect(-4 * One, 4 * One, -4 * One, 4 * One, 2 * One);
    send_ray(mk(0, 5 * One, 0, 0, -One, 0, 0, 10 * One));            // down, center
    send_ray(mk(One, -3 * One, One, 0, One, 0, 0, 10 * One));        // up, back face
    send_ray(mk(0, 5 * One, 0, One, 0, 0, IMin, IMax));              // parallel to plane
    send_ray(mk(0, 5 * One, 0, 0, -One, 0, 4 * One, 10 * One));      // t below interval
    send_ray(mk(0, 5 * One, 0, 0, -One, 0, 0, 2 * One));             // t above interval
    send_ray(mk(0, 5 * One, 0, 0, -One, 0, 3 * One, 3 * One));       // t exactly at both ends
    send_ray(mk(-4 * One, 3 * One, 0, 0, -One, 0, 0, IMax));         // x on lower bound
    send_ray(mk(4 * One, 3 * One, 4 * One, 0, -One, 0, 0, IMax));    // x, z on upper bounds
    send_ray(mk(4 * One + 1, 3 * One, 0, 0, -One, 0, 0, IMax));      // just outside x
    send_ray(mk(0, 3 * One, -4 * One - 1, 0, -One, 0, 0, IMax));     // just outside z
    send_ray(mk(-3 * One, 4 * One, -3 * One, One, -One, One, 0, IMax)); // oblique
    send_ray(mk(0, 3 * One, 0, -1, -3, 1, IMin, IMax));              // tiny direction
    send_ray(mk(IMax, IMax, IMax, IMax, IMax, IMax, IMax, IMax));    // all fields maximal
    send_ray(mk(IMin, IMin, IMin, IMin, IMin, IMin, IMin, IMin));    // all fields minimal
    send_ray(mk(0, IMin, 0, 0, 1, 0, IMin, IMax));                   // overflowing t
    send_ray(mk(0, 2 * One, 0, 0, IMin, 0, IMin, IMax));             // origin in plane
    send_ray(mk(0, 0, 0, 0, 0, 0, 0, 0));                            // zero ray
    send_ray(mk(3 * One, 2 * One + 1, 0, IMax, -1, 0, IMin, IMax));  // large product
    drain();
    random_rays(250);
    drain();

    // Full-range bounds with the plane at the bottom of the range.
    set_rect(IMin, IMax, IMin, IMax, IMin);
    send_ray(mk(IMax, 0, IMin, 0, IMin, 0, IMin, IMax));
    random_rays(250);
    drain();

    // Degenerate x extent: u must be zero on every hit.
    set_rect(One, One, -8 * One, 8 * One, -5 * One);
    random_rays(250);
    drain();

    // Inverted bounds: every ray misses.
    set_rect(4 * One, -4 * One, 2 * One, -2 * One, 0);
    random_rays(250);
    drain();

    // Small random box, plane at the top of the range, degenerate z extent.
    set_rect(-$urandom_range(1, 1 << 20), $urandom_range(1, 1 << 20), 7 * One, 7 * One, IMax);
    random_rays(250);
    drain();

    $display("sent %0d rays over five rectangle settings, %0d results, %0d hits",
             rays_sent, sb.results_seen, sb.hits_seen);
    if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
      $display("ray_xz_rectangle_intersect test passed");
    end else begin
      $display("ray_xz_rectangle_intersect test failed");
    end
    $finish;
  end
endmodule
